// File: rtl/assert_macros.svh
// Assertion shorthands for the RTL; included by tmbm_dp.
// Each macro assumes clk_i and rst_ni are visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TMBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define TMBM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/tmbm_pkg.sv
// Shared types and constants for the trimmed mean battery monitor.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package tmbm_pkg;

  localparam int unsigned SAMPLE_W        = 12;
  localparam int unsigned SUM_OUT_W       = 16;
  localparam int unsigned PCT_W           = 7;
  localparam int unsigned DEF_WINDOW_SIZE = 20;
  localparam int unsigned DEF_TRIM_COUNT  = 5;

  // Volts to percent: floor(sum * 1617 / (8192 * kept)) - 600, clamped to 0..100.
  localparam int unsigned SCALE_NUM   = 1617;
  localparam int unsigned SCALE_NUM_W = 11;
  localparam int unsigned SCALE_SHIFT = 13;
  localparam int unsigned PCT_OFFSET  = 600;
  localparam int unsigned PCT_MAX     = 100;
  localparam logic [PCT_W-1:0] LOW_PCT_RESET = 7'd25;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DRAIN,
    ST_SUM,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } tmbm_state_e;

  typedef struct packed {
    logic start;     // latch sample, clear sort row and sum
    logic rd_en;     // read window entry at index, insert it in the next cycle
    logic shift;     // shift sort row down by one
    logic acc_en;    // add bottom of sort row to sum
    logic mul1;      // scale sum
    logic mul2;      // divide by kept count
    logic load_out;  // load output register
    logic commit;    // mark window primed; advance ring pointer if already primed
  } tmbm_cmd_t;

  typedef struct packed {
    logic out_free;
  } tmbm_status_t;

endpackage

`default_nettype wire

// File: rtl/trimmed_mean_battery_monitor.sv
// Flow from input accept to out_valid_o: one window read per cycle into the insertion
// sort row, then the summing pass, two multiply stages and an output load; the load
// waits while the previous output word has not been taken.
// A new word is taken only once the last one is loaded out; the sort row is shared.
// Reset clears the ring pointer and primed flag; the first word fills the window.
// Top level; depends on tmbm_pkg, tmbm_ctrl and tmbm_dp.
`default_nettype none

module trimmed_mean_battery_monitor #(
  parameter int unsigned WINDOW_SIZE = tmbm_pkg::DEF_WINDOW_SIZE,
  parameter int unsigned TRIM_COUNT  = tmbm_pkg::DEF_TRIM_COUNT
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire [tmbm_pkg::SAMPLE_W-1:0]   adc_sample_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic [tmbm_pkg::SUM_OUT_W-1:0] trimmed_sum_o,
  output logic [tmbm_pkg::PCT_W-1:0]     battery_percent_o,
  output logic                           battery_low_o,
  input  wire                            cfg_we_i,
  input  wire [tmbm_pkg::PCT_W-1:0]      cfg_wdata_i
);
  import tmbm_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW_SIZE);

  tmbm_cmd_t        cmd;
  tmbm_status_t     sts;
  logic [IDX_W-1:0] idx;
  logic [PCT_W-1:0] low_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_pct_q <= LOW_PCT_RESET;
    end else if (cfg_we_i) begin
      low_pct_q <= cfg_wdata_i;
    end
  end

  tmbm_ctrl #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .TRIM_COUNT  (TRIM_COUNT),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  tmbm_dp #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .TRIM_COUNT  (TRIM_COUNT),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .idx_i             (idx),
    .sts_o             (sts),
    .adc_sample_i      (adc_sample_i),
    .low_pct_i         (low_pct_q),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .trimmed_sum_o     (trimmed_sum_o),
    .battery_percent_o (battery_percent_o),
    .battery_low_o     (battery_low_o)
  );

endmodule

`default_nettype wire

// File: rtl/tmbm_ctrl.sv
// Sequencer for the trimmed mean battery monitor.
// Depends on tmbm_pkg; drives the datapath through tmbm_cmd_t.
`default_nettype none

module tmbm_ctrl #(
  parameter int unsigned WINDOW_SIZE = tmbm_pkg::DEF_WINDOW_SIZE,
  parameter int unsigned TRIM_COUNT  = tmbm_pkg::DEF_TRIM_COUNT,
  parameter int unsigned IDX_W       = $clog2(WINDOW_SIZE)
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  tmbm_pkg::tmbm_status_t sts_i,
  output tmbm_pkg::tmbm_cmd_t   cmd_o,
  output logic [IDX_W-1:0]      idx_o
);
  import tmbm_pkg::*;

  // Last index of the summing pass: entries from WINDOW_SIZE - TRIM_COUNT up are dropped.
  localparam int unsigned SUM_LAST = (WINDOW_SIZE > TRIM_COUNT + 1) ?
                                     (WINDOW_SIZE - TRIM_COUNT - 1) : 0;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [IDX_W-1:0] SUM_END  = IDX_W'(SUM_LAST);

  tmbm_state_e      state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          cnt_d       = '0;
          state_d     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == IDX_LAST) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last read word lands in the sort row here
        state_d = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.shift  = 1'b1;
        cmd_o.acc_en = (int'(cnt_q) >= int'(TRIM_COUNT));
        if (cnt_q == SUM_END) begin
          cnt_d   = '0;
          state_d = ST_MUL1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.commit   = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign idx_o = cnt_q;

endmodule

`default_nettype wire

// File: rtl/tmbm_dp.sv
// Datapath: sample ring memory, insertion sort row, trimmed sum, percent scaling.
// Depends on tmbm_pkg and assert_macros.svh; steered by tmbm_ctrl.
`default_nettype none

module tmbm_dp #(
  parameter int unsigned WINDOW_SIZE = tmbm_pkg::DEF_WINDOW_SIZE,
  parameter int unsigned TRIM_COUNT  = tmbm_pkg::DEF_TRIM_COUNT,
  parameter int unsigned IDX_W       = $clog2(WINDOW_SIZE)
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  tmbm_pkg::tmbm_cmd_t               cmd_i,
  input  wire [IDX_W-1:0]                   idx_i,
  output tmbm_pkg::tmbm_status_t            sts_o,
  input  wire [tmbm_pkg::SAMPLE_W-1:0]      adc_sample_i,
  input  wire [tmbm_pkg::PCT_W-1:0]         low_pct_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [tmbm_pkg::SUM_OUT_W-1:0]    trimmed_sum_o,
  output logic [tmbm_pkg::PCT_W-1:0]        battery_percent_o,
  output logic                              battery_low_o
);
  import tmbm_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned SUM_W   = SAMPLE_W + $clog2(WINDOW_SIZE);
  localparam int unsigned PROD1_W = SUM_W + SCALE_NUM_W;
  localparam int unsigned T_W     = SUM_W - 2;  // width of sum * 1617 >> 13
  localparam int unsigned KEPT    = (WINDOW_SIZE > 2 * TRIM_COUNT) ?
                                    (WINDOW_SIZE - 2 * TRIM_COUNT) : 0;
  localparam int unsigned KEPT_D  = (KEPT > 0) ? KEPT : 1;
  localparam int unsigned RCP_SH  = T_W + $clog2(KEPT_D);
  localparam longint unsigned RCP = ((64'd1 << RCP_SH) + KEPT_D - 1) / KEPT_D;
  localparam logic [T_W:0] RCP_M  = (T_W + 1)'(RCP);
  localparam int unsigned PROD2_W = 2 * T_W + 1;
  localparam int unsigned ROW_W   = SAMPLE_W + 1;
  // Empty slot marker sorts above every sample.
  localparam logic [ROW_W-1:0] ROW_EMPTY = {1'b1, {SAMPLE_W{1'b0}}};

  logic [SAMPLE_W-1:0] win_mem [WINDOW_SIZE];
  logic [SAMPLE_W-1:0] rd_q;
  logic                rd_vld_q;
  logic                use_smp_q;
  logic [SAMPLE_W-1:0] smp_q;
  logic [IDX_W-1:0]    oldest_q;
  logic                primed_q;
  logic                mem_we;
  logic [ROW_W-1:0]    row_q [WINDOW_SIZE];
  logic [ROW_W-1:0]    row_d [WINDOW_SIZE];
  logic [ROW_W-1:0]    ins_val;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD1_W-1:0]  prod1_q;
  logic [PROD2_W-1:0]  prod2_q;
  logic [T_W-1:0]      quo;
  logic [T_W-1:0]      quo_off;
  logic [PCT_W-1:0]    pct;
  logic [SUM_OUT_W-1:0] sum_sat;
  logic                out_vld_q;
  logic [SUM_OUT_W-1:0] sum_out_q;
  logic [PCT_W-1:0]    pct_q;
  logic                low_q;

  // Overwrite every entry while priming, otherwise only the oldest one.
  assign mem_we = cmd_i.rd_en && (!primed_q || idx_i == oldest_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem[idx_i] <= smp_q;
    end
    if (cmd_i.rd_en) begin
      rd_q <= win_mem[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      oldest_q <= '0;
      primed_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_en;
      if (cmd_i.commit) begin
        primed_q <= 1'b1;
        if (primed_q) begin
          oldest_q <= (oldest_q == IDX_W'(WINDOW_SIZE - 1)) ? '0 : oldest_q + 1'b1;
        end
      end
    end
  end

  // Memory read returns pre-write data; take the new sample for the written slot.
  assign ins_val = use_smp_q ? {1'b0, smp_q} : {1'b0, rd_q};

  always_comb begin
    for (int j = 0; j < int'(WINDOW_SIZE); j++) begin
      row_d[j] = row_q[j];
      if (cmd_i.start) begin
        row_d[j] = ROW_EMPTY;
      end else if (rd_vld_q) begin
        if (row_q[j] > ins_val) begin
          if (j == 0) begin
            row_d[j] = ins_val;
          end else begin
            row_d[j] = (row_q[j-1] > ins_val) ? row_q[j-1] : ins_val;
          end
        end
      end else if (cmd_i.shift) begin
        row_d[j] = (j == int'(WINDOW_SIZE) - 1) ? ROW_EMPTY : row_q[(j + 1) % WINDOW_SIZE];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < int'(WINDOW_SIZE); j++) begin
      row_q[j] <= row_d[j];
    end
    if (cmd_i.start) begin
      smp_q <= adc_sample_i;
      sum_q <= '0;
    end else if (cmd_i.acc_en) begin
      sum_q <= sum_q + SUM_W'(row_q[0][SAMPLE_W-1:0]);
    end
    if (cmd_i.rd_en) begin
      use_smp_q <= mem_we;
    end
    if (cmd_i.mul1) begin
      prod1_q <= PROD1_W'(sum_q) * PROD1_W'(SCALE_NUM);
    end
    if (cmd_i.mul2) begin
      prod2_q <= PROD2_W'(prod1_q[PROD1_W-1:SCALE_SHIFT]) * PROD2_W'(RCP_M);
    end
  end

  // Clamp (q - 600) to 0..100.
  assign quo     = T_W'(prod2_q >> RCP_SH);
  assign quo_off = quo - T_W'(PCT_OFFSET);
  always_comb begin
    if (quo < T_W'(PCT_OFFSET)) begin
      pct = '0;
    end else if (quo_off > T_W'(PCT_MAX)) begin
      pct = PCT_W'(PCT_MAX);
    end else begin
      pct = PCT_W'(quo_off);
    end
  end

  assign sum_sat = (|(sum_q >> SUM_OUT_W)) ? {SUM_OUT_W{1'b1}} : SUM_OUT_W'(sum_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      sum_out_q <= sum_sat;
      pct_q     <= pct;
      low_q     <= (pct < low_pct_i);
    end
  end

  assign sts_o.out_free    = !out_vld_q || out_ready_i;
  assign out_valid_o       = out_vld_q;
  assign trimmed_sum_o     = sum_out_q;
  assign battery_percent_o = pct_q;
  assign battery_low_o     = low_q;

  `TMBM_ASSERT(a_load_no_clobber, cmd_i.load_out |-> (!out_vld_q || out_ready_i), "output word overwritten before taken")
  `TMBM_ASSERT(a_primed_sticky, primed_q |=> primed_q, "window primed flag dropped")
  `TMBM_ASSERT_NEVER(a_oldest_range, int'(oldest_q) >= int'(WINDOW_SIZE), "ring pointer out of range")
  `TMBM_ASSERT(a_pct_range, out_vld_q |-> (pct_q <= PCT_W'(PCT_MAX)), "battery percent above 100")

endmodule

`default_nettype wire
